FILE: rtl/core/adm_pkg.sv
// Package for the arcade drive mixer: fixed-point widths, register indexes
// and register reset values. No dependencies.
package adm_pkg;

   localparam int FRAC_BITS = 15;
   localparam int GAIN_FRAC = 12;

   localparam int CMD_W  = 16;
   localparam int DB_W   = 15;
   localparam int GAIN_W = 16;
   localparam int SPD_W  = 13;
   localparam int OUT_W  = 14;
   localparam int CSR_W  = 16;
   localparam int IDX_W  = 2;

   // deadband divider: quotient is at most 2^FRAC_BITS
   localparam int DB_Q_W   = FRAC_BITS + 1;
   localparam int DB_NUM_W = CMD_W + FRAC_BITS;
   localparam int DB_CMP_W = CMD_W + DB_Q_W;
   localparam int F_W      = FRAC_BITS + 2;

   // mix and speed divider
   localparam int MIX_W    = F_W + GAIN_W + 2;
   localparam int PROD_W   = MIX_W + SPD_W;

   localparam logic [IDX_W-1:0] REG_FWD_DB   = 2'd0;
   localparam logic [IDX_W-1:0] REG_TURN_DB  = 2'd1;
   localparam logic [IDX_W-1:0] REG_TURN_GN  = 2'd2;
   localparam logic [IDX_W-1:0] REG_MAX_SPD  = 2'd3;

   localparam logic [DB_W-1:0]   FWD_DB_RST  = 15'd3277;
   localparam logic [DB_W-1:0]   TURN_DB_RST = 15'd4915;
   localparam logic [GAIN_W-1:0] TURN_GN_RST = 16'd4096;
   localparam logic [SPD_W-1:0]  MAX_SPD_RST = 13'd3400;

endpackage

FILE: rtl/core/arcade_drive_mixer.sv
// Arcade drive mixer: deadband, mix, desaturation and speed scaling.
// Two pipelined dividers do the work: a 16-step deadband divider and a 13-step
// speed divider, one quotient bit per stage.
// Throughput: one item per cycle whenever the result side does not stall.
// Stall stops the whole pipeline; items are neither dropped nor repeated.
// Reset (synchronous) clears all valid bits and loads register defaults.
module arcade_drive_mixer
   import adm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [CMD_W-1:0] req_forward_cmd,
   input  logic signed [CMD_W-1:0] req_turn_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_left_speed,
   output logic signed [OUT_W-1:0] rsp_right_speed,
   output logic                    rsp_desaturated,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int DB_STEPS = DB_Q_W;
   localparam int SP_STEPS = SPD_W;
   localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << (FRAC_BITS + GAIN_FRAC);
   localparam logic [CMD_W:0]   CMD_ONE = (CMD_W+1)'(1) << (CMD_W - 1);

   // configuration
   logic [DB_W-1:0]   fwd_db_ff, turn_db_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [SPD_W-1:0]  max_spd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_db_ff  <= FWD_DB_RST;
         turn_db_ff <= TURN_DB_RST;
         gain_ff    <= TURN_GN_RST;
         max_spd_ff <= MAX_SPD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FWD_DB:  fwd_db_ff  <= csr_wdata[DB_W-1:0];
            REG_TURN_DB: turn_db_ff <= csr_wdata[DB_W-1:0];
            REG_TURN_GN: gain_ff    <= csr_wdata[GAIN_W-1:0];
            REG_MAX_SPD: max_spd_ff <= csr_wdata[SPD_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 0: input capture
   logic                    v0_ff;
   logic signed [CMD_W-1:0] cmd0_ff [2];

   // deadband divider, lane 0 = forward, lane 1 = turn
   logic                db_v_ff   [DB_STEPS+1];
   logic [DB_NUM_W-1:0] db_rem_ff [2][DB_STEPS+1];
   logic [DB_NUM_W-1:0] db_rem_in [2][DB_STEPS+1];
   logic [DB_Q_W-1:0]   db_q_ff   [2][DB_STEPS+1];
   logic [DB_Q_W-1:0]   db_q_in   [2][DB_STEPS+1];
   logic [CMD_W-1:0]    db_den_ff [2][DB_STEPS+1];
   logic [CMD_W-1:0]    db_den_in [2];
   logic                db_neg_ff [2][DB_STEPS+1];
   logic                db_neg_in [2];

   always_comb begin
      logic signed [CMD_W:0] x;
      logic [CMD_W:0]        mag;
      logic [CMD_W:0]        db;
      logic [DB_CMP_W-1:0]   trial;
      for (int ln = 0; ln < 2; ln++) begin
         x  = (CMD_W+1)'(cmd0_ff[ln]);
         db = (ln == 0) ? (CMD_W+1)'(fwd_db_ff) : (CMD_W+1)'(turn_db_ff);
         db_neg_in[ln] = x[CMD_W];
         mag = x[CMD_W] ? (CMD_W+1)'(-x) : (CMD_W+1)'(x);
         db_den_in[ln] = CMD_W'(CMD_ONE - db);
         if (mag < db)
            db_rem_in[ln][0] = '0;
         else
            db_rem_in[ln][0] = DB_NUM_W'(mag - db) << FRAC_BITS;
         db_q_in[ln][0] = '0;
         for (int i = 0; i < DB_STEPS; i++) begin
            trial = DB_CMP_W'(db_den_ff[ln][i]) << (DB_STEPS - 1 - i);
            db_rem_in[ln][i+1] = db_rem_ff[ln][i];
            db_q_in[ln][i+1]   = db_q_ff[ln][i];
            if (DB_CMP_W'(db_rem_ff[ln][i]) >= trial) begin
               db_rem_in[ln][i+1] = DB_NUM_W'(DB_CMP_W'(db_rem_ff[ln][i]) - trial);
               db_q_in[ln][i+1][DB_STEPS-1-i] = 1'b1;
            end
         end
      end
   end

   // mix stages
   logic                    v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [F_W-1:0]   f2_ff, t2_ff;
   logic signed [MIX_W-1:0] fa3_ff, tg3_ff;
   logic signed [MIX_W-1:0] a4_ff, b4_ff;
   logic [MIX_W-1:0]        am5_ff, bm5_ff;
   logic                    an5_ff, bn5_ff;
   logic signed [F_W-1:0]   f2_in, t2_in;
   logic signed [MIX_W-1:0] fa3_in, tg3_in, gain_s;

   always_comb begin
      f2_in = db_neg_ff[0][DB_STEPS] ? -$signed(F_W'(db_q_ff[0][DB_STEPS]))
                                     :  $signed(F_W'(db_q_ff[0][DB_STEPS]));
      t2_in = db_neg_ff[1][DB_STEPS] ? -$signed(F_W'(db_q_ff[1][DB_STEPS]))
                                     :  $signed(F_W'(db_q_ff[1][DB_STEPS]));
      gain_s = $signed(MIX_W'(gain_ff));
      fa3_in = MIX_W'(f2_ff) <<< GAIN_FRAC;
      tg3_in = MIX_W'(t2_ff) * gain_s;
   end

   // speed divider, lane 0 = left, lane 1 = right
   logic              sp_v_ff   [SP_STEPS+1];
   logic [PROD_W-1:0] sp_rem_ff [2][SP_STEPS+1];
   logic [PROD_W-1:0] sp_rem_in [2][SP_STEPS+1];
   logic [SPD_W-1:0]  sp_q_ff   [2][SP_STEPS+1];
   logic [SPD_W-1:0]  sp_q_in   [2][SP_STEPS+1];
   logic              sp_neg_ff [2][SP_STEPS+1];
   logic [MIX_W-1:0]  sp_den_ff [SP_STEPS+1];
   logic              sp_sat_ff [SP_STEPS+1];
   logic [MIX_W-1:0]  m_in;

   always_comb begin
      logic [PROD_W-1:0] trial;
      m_in = MIX_ONE;
      if (am5_ff > m_in) m_in = am5_ff;
      if (bm5_ff > m_in) m_in = bm5_ff;
      sp_rem_in[0][0] = PROD_W'(am5_ff) * PROD_W'(max_spd_ff);
      sp_rem_in[1][0] = PROD_W'(bm5_ff) * PROD_W'(max_spd_ff);
      for (int ln = 0; ln < 2; ln++) begin
         sp_q_in[ln][0] = '0;
         for (int i = 0; i < SP_STEPS; i++) begin
            trial = PROD_W'(sp_den_ff[i]) << (SP_STEPS - 1 - i);
            sp_rem_in[ln][i+1] = sp_rem_ff[ln][i];
            sp_q_in[ln][i+1]   = sp_q_ff[ln][i];
            if (sp_rem_ff[ln][i] >= trial) begin
               sp_rem_in[ln][i+1] = sp_rem_ff[ln][i] - trial;
               sp_q_in[ln][i+1][SP_STEPS-1-i] = 1'b1;
            end
         end
      end
   end

   logic signed [OUT_W-1:0] left_ff, right_ff;
   logic                    desat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= DB_STEPS; i++) db_v_ff[i] <= 1'b0;
         for (int i = 0; i <= SP_STEPS; i++) sp_v_ff[i] <= 1'b0;
      end else if (adv) begin
         v0_ff      <= req_valid;
         db_v_ff[0] <= v0_ff;
         for (int i = 0; i < DB_STEPS; i++) db_v_ff[i+1] <= db_v_ff[i];
         v2_ff      <= db_v_ff[DB_STEPS];
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         v5_ff      <= v4_ff;
         sp_v_ff[0] <= v5_ff;
         for (int i = 0; i < SP_STEPS; i++) sp_v_ff[i+1] <= sp_v_ff[i];
         rsp_valid_ff <= sp_v_ff[SP_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd0_ff[0] <= req_forward_cmd;
         cmd0_ff[1] <= req_turn_cmd;
         for (int ln = 0; ln < 2; ln++) begin
            db_den_ff[ln][0] <= db_den_in[ln];
            db_neg_ff[ln][0] <= db_neg_in[ln];
            for (int i = 0; i <= DB_STEPS; i++) begin
               db_rem_ff[ln][i] <= db_rem_in[ln][i];
               db_q_ff[ln][i]   <= db_q_in[ln][i];
            end
            for (int i = 0; i < DB_STEPS; i++) begin
               db_den_ff[ln][i+1] <= db_den_ff[ln][i];
               db_neg_ff[ln][i+1] <= db_neg_ff[ln][i];
            end
         end
         f2_ff  <= f2_in;
         t2_ff  <= t2_in;
         fa3_ff <= fa3_in;
         tg3_ff <= tg3_in;
         a4_ff  <= fa3_ff + tg3_ff;
         b4_ff  <= fa3_ff - tg3_ff;
         an5_ff <= a4_ff[MIX_W-1];
         bn5_ff <= b4_ff[MIX_W-1];
         am5_ff <= a4_ff[MIX_W-1] ? MIX_W'(-a4_ff) : MIX_W'(a4_ff);
         bm5_ff <= b4_ff[MIX_W-1] ? MIX_W'(-b4_ff) : MIX_W'(b4_ff);
         sp_den_ff[0]    <= m_in;
         sp_sat_ff[0]    <= (m_in > MIX_ONE);
         sp_neg_ff[0][0] <= an5_ff;
         sp_neg_ff[1][0] <= bn5_ff;
         for (int ln = 0; ln < 2; ln++) begin
            for (int i = 0; i <= SP_STEPS; i++) begin
               sp_rem_ff[ln][i] <= sp_rem_in[ln][i];
               sp_q_ff[ln][i]   <= sp_q_in[ln][i];
            end
            for (int i = 0; i < SP_STEPS; i++)
               sp_neg_ff[ln][i+1] <= sp_neg_ff[ln][i];
         end
         for (int i = 0; i < SP_STEPS; i++) begin
            sp_den_ff[i+1] <= sp_den_ff[i];
            sp_sat_ff[i+1] <= sp_sat_ff[i];
         end
         left_ff  <= sp_neg_ff[0][SP_STEPS] ? -$signed(OUT_W'(sp_q_ff[0][SP_STEPS]))
                                            :  $signed(OUT_W'(sp_q_ff[0][SP_STEPS]));
         right_ff <= sp_neg_ff[1][SP_STEPS] ? -$signed(OUT_W'(sp_q_ff[1][SP_STEPS]))
                                            :  $signed(OUT_W'(sp_q_ff[1][SP_STEPS]));
         desat_ff <= sp_sat_ff[SP_STEPS];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_desaturated = desat_ff;

   // deadband output never exceeds 1.0
   a_db_range: assert property (@(posedge clock) disable iff (reset)
      db_v_ff[DB_STEPS] |->
         (db_q_ff[0][DB_STEPS] <= (DB_Q_W'(1) << FRAC_BITS)) &&
         (db_q_ff[1][DB_STEPS] <= (DB_Q_W'(1) << FRAC_BITS)))
      else $error("deadband quotient above unity");

   // scaled speed stays within max speed
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_v_ff[SP_STEPS] |->
         (sp_q_ff[0][SP_STEPS] <= max_spd_ff) && (sp_q_ff[1][SP_STEPS] <= max_spd_ff))
      else $error("speed quotient above max speed");

   // an item in stage 0 moves into the divider when the pipe advances
   a_v_move: assert property (@(posedge clock) disable iff (reset)
      adv && v0_ff |=> db_v_ff[0])
      else $error("item lost entering divider");

   // a held result does not move
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(left_ff) && $stable(right_ff))
      else $error("stalled result changed");

endmodule
